FILE: design/anchor_table_aging_round_robin_unit_defines.svh
// Assertion macros for the anchor table unit.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef ANCHOR_TABLE_AGING_ROUND_ROBIN_UNIT_DEFINES_SVH
`define ANCHOR_TABLE_AGING_ROUND_ROBIN_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ATR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ATR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/atr_pkg.sv
// Shared types and constants for the anchor table unit.
// No dependencies.
package atr_pkg;

    localparam int          ANCHORS_DEF  = 16;
    localparam logic [31:0] EXPIRE_RESET = 32'd3000;

    typedef enum logic [1:0] {
        CMD_REPORT = 2'd0,
        CMD_SIGHT  = 2'd1,
        CMD_SWEEP  = 2'd2,
        CMD_POLL   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [15:0]        address;
        logic [7:0]         seq_num;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] range_value;
        logic [31:0]        expiry;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/atr_if.sv
// Valid/ready channel interfaces for the anchor table unit.
// Depends on nothing; payload widths are fixed.
interface atr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [15:0]        address;
    logic [7:0]         sequence_req;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] range_value;
    logic [31:0]        now_ms;

    modport source (output valid, command, address, sequence_req, pos_x, pos_y,
                    range_value, now_ms, input ready);
    modport sink (input valid, command, address, sequence_req, pos_x, pos_y,
                  range_value, now_ms, output ready);
endinterface

interface atr_res_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [3:0]  slot;
    logic        poll_valid;
    logic [15:0] poll_address;
    logic [7:0]  poll_sequence;
    logic [4:0]  anchor_count;
    logic [4:0]  removed_count;

    modport source (output valid, hit, slot, poll_valid, poll_address, poll_sequence,
                    anchor_count, removed_count, input ready);
    modport sink (input valid, hit, slot, poll_valid, poll_address, poll_sequence,
                  anchor_count, removed_count, output ready);
endinterface

FILE: design/atr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/atr_seq.sv
// Item sequencer for the anchor table: occupancy flags, slot walk, read-modify-write.
// Depends on atr_pkg, atr_if and the assertion macro header; drives atr_ram.
`include "anchor_table_aging_round_robin_unit_defines.svh"

module atr_seq
    import atr_pkg::*;
#(
    parameter int ANCHORS = ANCHORS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [31:0]                                   expire_ms,
    atr_in_if.sink                                        in_ch,
    atr_res_if.source                                     res_ch,
    output logic                                          mem_wr_en,
    output logic [((ANCHORS > 1) ? $clog2(ANCHORS) : 1)-1:0] mem_wr_addr,
    output logic [ENTRY_W-1:0]                            mem_wr_data,
    output logic                                          mem_rd_en,
    output logic [((ANCHORS > 1) ? $clog2(ANCHORS) : 1)-1:0] mem_rd_addr,
    input  logic [ENTRY_W-1:0]                            mem_rd_data
);

    localparam int          IW   = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
    localparam int          CW   = $clog2(ANCHORS + 1);
    localparam int          SW   = (IW > 4) ? IW : 4;
    localparam int          NW   = (CW > 5) ? CW : 5;
    localparam logic [IW-1:0] LAST = IW'(ANCHORS - 1);
    localparam logic [CW-1:0] FULL = CW'(ANCHORS);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_STEP  = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        poll_valid;
        logic [15:0] poll_address;
        logic [7:0]  poll_sequence;
        logic [4:0]  anchor_count;
        logic [4:0]  removed_count;
    } res_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [15:0]        addr_reg, addr_next;
    logic [7:0]         seq_reg, seq_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] rng_reg, rng_next;
    logic [31:0]        now_reg, now_next;

    logic [ANCHORS-1:0] occ_reg, occ_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      poll_reg, poll_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IW-1:0]      chk_idx_reg, chk_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic [IW-1:0]      target_reg, target_next;
    logic [IW-1:0]      step_reg, step_next;
    logic               hit_reg, hit_next;
    logic [IW-1:0]      slot_reg, slot_next;
    logic [CW-1:0]      removed_reg, removed_next;
    logic               pvalid_reg, pvalid_next;
    logic [15:0]        paddr_reg, paddr_next;
    logic [7:0]         pseq_reg, pseq_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               issue;
    logic               chk_last;
    logic               match;
    logic               free_here;
    logic               expired;
    logic [31:0]        age;
    logic [IW-1:0]      poll_inc;
    logic [SW-1:0]      slot_ext;
    logic [NW-1:0]      count_ext;
    logic [NW-1:0]      removed_ext;

    assign rd_entry    = entry_t'(mem_rd_data);
    assign issue       = (state_reg == ST_SCAN) && (scan_reg != FULL);
    assign chk_last    = (chk_idx_reg == LAST);
    assign match       = chk_vld_reg && occ_reg[chk_idx_reg] && (rd_entry.address == addr_reg);
    assign free_here   = chk_vld_reg && !occ_reg[chk_idx_reg];
    assign age         = now_reg - rd_entry.expiry;
    assign expired     = (age != 32'd0) && !age[31];
    assign poll_inc    = (poll_reg == LAST) ? '0 : poll_reg + IW'(1);
    assign slot_ext    = SW'(slot_reg);
    assign count_ext   = NW'(count_reg);
    assign removed_ext = NW'(removed_reg);

    assign in_ch.ready = (state_reg == ST_IDLE);

    assign mem_rd_en   = issue || (state_reg == ST_FETCH);
    assign mem_rd_addr = (state_reg == ST_FETCH) ? target_reg : scan_reg[IW-1:0];
    assign mem_wr_en   = (state_reg == ST_WRITE);
    assign mem_wr_addr = target_reg;
    assign mem_wr_data = wr_entry;

    always_comb
    begin
        wr_entry = rd_entry;
        if (cmd_reg == CMD_POLL)
        begin
            wr_entry.seq_num = rd_entry.seq_num + 8'd1;
        end
        else
        begin
            wr_entry.address = addr_reg;
            wr_entry.seq_num = seq_reg;
            wr_entry.expiry  = now_reg + expire_ms;
            if (cmd_reg == CMD_REPORT)
            begin
                wr_entry.pos_x       = x_reg;
                wr_entry.pos_y       = y_reg;
                wr_entry.range_value = rng_reg;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        seq_next        = seq_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        rng_next        = rng_reg;
        now_next        = now_reg;
        occ_next        = occ_reg;
        count_next      = count_reg;
        poll_next       = poll_reg;
        scan_next       = scan_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = scan_reg[IW-1:0];
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        target_next     = target_reg;
        step_next       = step_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        removed_next    = removed_reg;
        pvalid_next     = pvalid_reg;
        paddr_next      = paddr_reg;
        pseq_next       = pseq_reg;
        out_valid_next  = out_valid_reg && !res_ch.ready;
        out_next        = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cmd_next        = cmd_t'(in_ch.command);
                    addr_next       = in_ch.address;
                    seq_next        = in_ch.sequence_req;
                    x_next          = in_ch.pos_x;
                    y_next          = in_ch.pos_y;
                    rng_next        = in_ch.range_value;
                    now_next        = in_ch.now_ms;
                    scan_next       = '0;
                    step_next       = '0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    slot_next       = '0;
                    removed_next    = '0;
                    pvalid_next     = 1'b0;
                    paddr_next      = '0;
                    pseq_next       = '0;
                    case (cmd_t'(in_ch.command))
                        CMD_REPORT, CMD_SIGHT:
                            state_next = (in_ch.address == 16'd0) ? ST_DONE : ST_SCAN;
                        CMD_SWEEP:
                            state_next = ST_SCAN;
                        CMD_POLL:
                            state_next = ST_STEP;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                if (cmd_reg == CMD_SWEEP)
                begin
                    if (chk_vld_reg && occ_reg[chk_idx_reg] && expired)
                    begin
                        occ_next[chk_idx_reg] = 1'b0;
                        count_next            = count_reg - CW'(1);
                        removed_next          = removed_reg + CW'(1);
                        slot_next             = chk_idx_reg;
                    end
                    if (chk_vld_reg && chk_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (match)
                begin
                    hit_next    = 1'b1;
                    target_next = chk_idx_reg;
                    state_next  = ST_FETCH;
                end
                else
                begin
                    if (free_here && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (chk_vld_reg && chk_last)
                    begin
                        if (free_found_reg)
                        begin
                            target_next = free_idx_reg;
                        end
                        else if (free_here)
                        begin
                            target_next = chk_idx_reg;
                        end
                        else
                        begin
                            target_next = '0;
                        end
                        state_next = ST_FETCH;
                    end
                end
                if (state_next == ST_SCAN)
                begin
                    chk_vld_next = issue;
                end
            end

            ST_STEP:
            begin
                poll_next = poll_inc;
                slot_next = poll_inc;
                step_next = step_reg + IW'(1);
                if (occ_reg[poll_inc])
                begin
                    target_next = poll_inc;
                    state_next  = ST_FETCH;
                end
                else if (step_reg == LAST)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_FETCH:
            begin
                state_next = ST_WRITE;
            end

            ST_WRITE:
            begin
                occ_next[target_reg] = 1'b1;
                if (!occ_reg[target_reg])
                begin
                    count_next = count_reg + CW'(1);
                end
                slot_next = target_reg;
                if (cmd_reg == CMD_POLL)
                begin
                    pvalid_next = 1'b1;
                    paddr_next  = rd_entry.address;
                    pseq_next   = wr_entry.seq_num;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || res_ch.ready)
                begin
                    out_next.hit           = hit_reg;
                    out_next.slot          = slot_ext[3:0];
                    out_next.poll_valid    = pvalid_reg;
                    out_next.poll_address  = paddr_reg;
                    out_next.poll_sequence = pseq_reg;
                    out_next.anchor_count  = count_ext[4:0];
                    out_next.removed_count = removed_ext[4:0];
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            count_reg     <= '0;
            poll_reg      <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            count_reg     <= count_next;
            poll_reg      <= poll_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        seq_reg        <= seq_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        rng_reg        <= rng_next;
        now_reg        <= now_next;
        scan_reg       <= scan_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        target_reg     <= target_next;
        step_reg       <= step_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        removed_reg    <= removed_next;
        pvalid_reg     <= pvalid_next;
        paddr_reg      <= paddr_next;
        pseq_reg       <= pseq_next;
        out_reg        <= out_next;
    end

    assign res_ch.valid         = out_valid_reg;
    assign res_ch.hit           = out_reg.hit;
    assign res_ch.slot          = out_reg.slot;
    assign res_ch.poll_valid    = out_reg.poll_valid;
    assign res_ch.poll_address  = out_reg.poll_address;
    assign res_ch.poll_sequence = out_reg.poll_sequence;
    assign res_ch.anchor_count  = out_reg.anchor_count;
    assign res_ch.removed_count = out_reg.removed_count;

    `ATR_ASSERT_NOW(a_no_rw_same_slot, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "read and write collide on one slot")
    `ATR_ASSERT_NOW(a_count_matches_occ, 1'b1, count_reg == CW'($countones(occ_reg)), "anchor count out of step with occupancy")
    `ATR_ASSERT_NEXT(a_write_marks_occ, state_reg == ST_WRITE, occ_reg[$past(target_reg)], "written slot not marked occupied")
    `ATR_ASSERT_NEXT(a_done_presents, (state_reg == ST_DONE) && (!out_valid_reg || res_ch.ready), out_valid_reg && (state_reg == ST_IDLE), "result not presented on completion")

endmodule

FILE: design/anchor_table_aging_round_robin_unit.sv
// Anchor table with aging and round-robin poll: one item at a time. A report,
// sighting or sweep walks the slot RAM one entry a cycle through its registered
// read port, a poll the occupancy flags. A report or sighting ends its scan on a
// match or at the last slot, then fetches and writes back one entry, as a poll
// does for the next occupied slot; a report or sighting with address zero goes
// straight to the result. A new item is taken while the previous result still
// waits in the output register. The user must write expire_ms only while no item is in flight; it is not enforced.
// Depends on atr_pkg, atr_if, atr_ram and atr_seq.
module anchor_table_aging_round_robin_unit
    import atr_pkg::*;
#(
    parameter int ANCHORS = ANCHORS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    atr_in_if.sink      in_ch,
    atr_res_if.source   res_ch
);

    localparam int IW = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;

    logic [31:0]        expire_ms_reg;
    logic               mem_wr_en;
    logic [IW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [IW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expire_ms_reg <= EXPIRE_RESET;
        end
        else if (cfg_wr_en)
        begin
            expire_ms_reg <= cfg_wr_data;
        end
    end

    atr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ANCHORS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    atr_seq #(
        .ANCHORS (ANCHORS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .expire_ms   (expire_ms_reg),
        .in_ch       (in_ch),
        .res_ch      (res_ch),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

endmodule
